[hw/rtl/deque_with_delete_by_value_assert.svh]
// ---------------------------------------------------------------------------
// Deque assertion macros
// Clocked assertion helpers shared by the deque RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef DEQUE_WITH_DELETE_BY_VALUE_ASSERT_SVH
`define DEQUE_WITH_DELETE_BY_VALUE_ASSERT_SVH

`ifndef SYNTHESIS
// combinational implication checked every cycle outside reset
`define DWD_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque assertion failed");
// implication whose consequent is checked in the next cycle
`define DWD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque assertion failed");
`else
`define DWD_ASSERT_IMPLY(label, ante, cons)
`define DWD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/dwd_pkg.sv]
// ---------------------------------------------------------------------------
// Deque package
// Sizes, request modes, status codes and word types of the deque.
// ---------------------------------------------------------------------------
package dwd_pkg;

   localparam int DEPTH      = 16;
   localparam int ITEM_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      MODE_PREPEND = 2'd0,
      MODE_APPEND  = 2'd1,
      MODE_DEQUEUE = 2'd2,
      MODE_DELETE  = 2'd3
   } mode_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      mode_type              mode;
      logic [ITEM_WIDTH-1:0] item_value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [ITEM_WIDTH-1:0] item_out;
      logic [CNT_W-1:0]      entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      addr;
      logic [ITEM_WIDTH-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } rsp_push_type;

   // physical slot of the entry at a given offset from the head
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, offset};
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

[hw/rtl/deque_with_delete_by_value.sv]
// ---------------------------------------------------------------------------
// Deque with delete by value
// Bounded double-ended queue of tags with prepend, append, dequeue and
// order-keeping delete of all matching entries.
// ---------------------------------------------------------------------------
// One request word is taken at a time and gives one response word. Prepend
// and append go from idle straight to the send state; dequeue passes through
// an extra state for the registered memory read, and delete stays in the
// delete state while the sequencer walks every held entry through the single
// read port and compares it against the tag, writing keepers back in place
// through the write port. Delete on an empty queue goes straight to the send
// state. The response register lets a new request be taken while the last
// response is still stalled; a finished request waits in the sequencer only
// when that register is still full. No clearing pass follows reset.
`include "deque_with_delete_by_value_assert.svh"

module deque_with_delete_by_value (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dwd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dwd_pkg::rsp_word_type rsp_word
);

   dwd_pkg::mem_wr_type            mem_wr;
   logic [dwd_pkg::IDX_W-1:0]      mem_rd_addr;
   logic [dwd_pkg::ITEM_WIDTH-1:0] mem_rd_data;
   dwd_pkg::rsp_push_type          push;
   logic                           slot_free;
   logic                           rsp_valid_ff, rsp_valid_in;
   dwd_pkg::rsp_word_type          rsp_word_ff, rsp_word_in;

   dwd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .slot_free   (slot_free),
      .push        (push),
      .mem_wr      (mem_wr),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   dwd_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = push.word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `DWD_ASSERT_IMPLY(a_push_into_free_slot, push.valid, slot_free)
   `DWD_ASSERT_IMPLY(a_count_in_range, rsp_valid, rsp_word.entry_count <= dwd_pkg::FULL_COUNT)
   `DWD_ASSERT_IMPLY(a_full_means_full, rsp_valid && rsp_word.status == dwd_pkg::ST_FULL, rsp_word.entry_count == dwd_pkg::FULL_COUNT)
   `DWD_ASSERT_NEXT(a_push_lands, push.valid, rsp_valid)

endmodule

[hw/rtl/dwd_store.sv]
// ---------------------------------------------------------------------------
// Deque entry store
// Entry memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module dwd_store (
   input  logic                           clock,
   input  dwd_pkg::mem_wr_type            wr,
   input  logic [dwd_pkg::IDX_W-1:0]      rd_addr,
   output logic [dwd_pkg::ITEM_WIDTH-1:0] rd_data
);

   logic [dwd_pkg::ITEM_WIDTH-1:0] entry_mem_ff [dwd_pkg::DEPTH];
   logic [dwd_pkg::ITEM_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/dwd_ctrl.sv]
// ---------------------------------------------------------------------------
// Deque sequencer
// Head/occupancy bookkeeping and the compare-and-compact walk for delete.
// ---------------------------------------------------------------------------
module dwd_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  dwd_pkg::req_word_type          req_word,
   input  logic                           slot_free,
   output dwd_pkg::rsp_push_type          push,
   output dwd_pkg::mem_wr_type            mem_wr,
   output logic [dwd_pkg::IDX_W-1:0]      mem_rd_addr,
   input  logic [dwd_pkg::ITEM_WIDTH-1:0] mem_rd_data
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DEQ  = 4'b0010,
      S_DEL  = 4'b0100,
      S_SEND = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   logic [dwd_pkg::IDX_W-1:0]      head_ff, head_in;
   logic [dwd_pkg::CNT_W-1:0]      occ_ff, occ_in;
   logic [dwd_pkg::ITEM_WIDTH-1:0] tag_ff, tag_in;
   logic [dwd_pkg::CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [dwd_pkg::CNT_W-1:0]      wr_cnt_ff, wr_cnt_in;
   logic                           pend_ff, pend_in;
   dwd_pkg::rsp_word_type          res_ff, res_in;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      occ_in      = occ_ff;
      tag_in      = tag_ff;
      rd_idx_in   = rd_idx_ff;
      wr_cnt_in   = wr_cnt_ff;
      pend_in     = pend_ff;
      res_in      = res_ff;
      mem_wr      = '0;
      mem_rd_addr = head_ff;
      push.valid  = 1'b0;
      push.word   = res_ff;
      req_stall   = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in.status   = dwd_pkg::ST_OK;
               res_in.item_out = '0;
               state_in        = S_SEND;
               case (req_word.mode)
                  dwd_pkg::MODE_PREPEND: begin
                     if (occ_ff == dwd_pkg::FULL_COUNT) begin
                        res_in.status = dwd_pkg::ST_FULL;
                     end else begin
                        head_in     = (head_ff == '0) ? dwd_pkg::IDX_W'(dwd_pkg::DEPTH - 1)
                                                      : head_ff - dwd_pkg::IDX_W'(1);
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = head_in;
                        mem_wr.data = req_word.item_value;
                        occ_in      = occ_ff + dwd_pkg::CNT_W'(1);
                     end
                  end
                  dwd_pkg::MODE_APPEND: begin
                     if (occ_ff == dwd_pkg::FULL_COUNT) begin
                        res_in.status = dwd_pkg::ST_FULL;
                     end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = dwd_pkg::slot_of(head_ff, occ_ff);
                        mem_wr.data = req_word.item_value;
                        occ_in      = occ_ff + dwd_pkg::CNT_W'(1);
                     end
                  end
                  dwd_pkg::MODE_DEQUEUE: begin
                     if (occ_ff == '0) begin
                        res_in.status = dwd_pkg::ST_EMPTY;
                     end else begin
                        // read at the old head is issued this cycle
                        head_in  = dwd_pkg::slot_of(head_ff, dwd_pkg::CNT_W'(1));
                        occ_in   = occ_ff - dwd_pkg::CNT_W'(1);
                        state_in = S_DEQ;
                     end
                  end
                  dwd_pkg::MODE_DELETE: begin
                     if (occ_ff == '0) begin
                        res_in.status = dwd_pkg::ST_EMPTY;
                     end else begin
                        tag_in    = req_word.item_value;
                        rd_idx_in = dwd_pkg::CNT_W'(1);
                        wr_cnt_in = '0;
                        pend_in   = 1'b1;
                        state_in  = S_DEL;
                     end
                  end
                  default: begin
                     res_in.status = dwd_pkg::ST_EMPTY;
                  end
               endcase
               res_in.entry_count = occ_in;
            end
         end
         S_DEQ: begin
            res_in.item_out = mem_rd_data;
            state_in        = S_SEND;
         end
         S_DEL: begin
            mem_rd_addr = dwd_pkg::slot_of(head_ff, rd_idx_ff);
            if (pend_ff) begin
               // keepers slide down to the write index; it never passes the read index
               if (mem_rd_data != tag_ff) begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = dwd_pkg::slot_of(head_ff, wr_cnt_ff);
                  mem_wr.data = mem_rd_data;
                  wr_cnt_in   = wr_cnt_ff + dwd_pkg::CNT_W'(1);
               end
               if (rd_idx_ff < occ_ff) begin
                  rd_idx_in = rd_idx_ff + dwd_pkg::CNT_W'(1);
               end else begin
                  pend_in = 1'b0;
               end
            end else begin
               occ_in             = wr_cnt_ff;
               res_in.status      = (wr_cnt_ff == occ_ff) ? dwd_pkg::ST_EMPTY
                                                          : dwd_pkg::ST_OK;
               res_in.item_out    = '0;
               res_in.entry_count = wr_cnt_ff;
               state_in           = S_SEND;
            end
         end
         S_SEND: begin
            push.valid = slot_free;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff    <= tag_in;
      rd_idx_ff <= rd_idx_in;
      wr_cnt_ff <= wr_cnt_in;
      res_ff    <= res_in;
   end

endmodule

[sim/deque_with_delete_by_value_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Deque with delete by value testbench
// Drives prepend, append, dequeue and delete words with random gaps and
// response stalls, predicts every response word from a shadow copy of the
// queue and compares status, dequeued tag and entry count field by field.
// ---------------------------------------------------------------------------
module deque_with_delete_by_value_tb;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES  = 40;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   dwd_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   dwd_pkg::rsp_word_type rsp_word;

   // shadow of the queue contents, front first
   logic [dwd_pkg::ITEM_WIDTH-1:0] shadow_tags[$];
   // response words still owed by the block, oldest first
   dwd_pkg::rsp_word_type          rsp_due[$];

   logic [dwd_pkg::ITEM_WIDTH-1:0] tag_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                    32'h8000_0001, 32'h0000_1234};

   int unsigned fail_count    = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned stall_pct     = 0;
   int unsigned rsp_hold_req  = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_run_left  = 0;

   deque_with_delete_by_value i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // applies one request word to the shadow queue, returns the response due
   function automatic dwd_pkg::rsp_word_type deque_predict(input dwd_pkg::req_word_type w);
      dwd_pkg::rsp_word_type          r;
      logic [dwd_pkg::ITEM_WIDTH-1:0] kept[$];
      r = '0;
      r.status = dwd_pkg::ST_OK;
      case (w.mode)
         dwd_pkg::MODE_PREPEND, dwd_pkg::MODE_APPEND: begin
            if (shadow_tags.size() >= dwd_pkg::DEPTH) begin
               r.status = dwd_pkg::ST_FULL;
            end else if (w.mode == dwd_pkg::MODE_PREPEND) begin
               shadow_tags.push_front(w.item_value);
            end else begin
               shadow_tags.push_back(w.item_value);
            end
         end
         dwd_pkg::MODE_DEQUEUE: begin
            if (shadow_tags.size() == 0) begin
               r.status = dwd_pkg::ST_EMPTY;
            end else begin
               r.item_out = shadow_tags.pop_front();
            end
         end
         default: begin
            foreach (shadow_tags[i]) begin
               if (shadow_tags[i] != w.item_value) begin
                  kept.push_back(shadow_tags[i]);
               end
            end
            if (kept.size() == shadow_tags.size()) begin
               r.status = dwd_pkg::ST_EMPTY;  // empty or no match
            end else begin
               shadow_tags = kept;
            end
         end
      endcase
      r.entry_count = dwd_pkg::CNT_W'(shadow_tags.size());
      return r;
   endfunction

   function automatic dwd_pkg::req_word_type mk_req(input dwd_pkg::mode_type m,
                                                    input logic [dwd_pkg::ITEM_WIDTH-1:0] v);
      dwd_pkg::req_word_type w;
      w.mode       = m;
      w.item_value = v;
      return w;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // delete tags lean toward held tags so that matches are common
   function automatic dwd_pkg::req_word_type pick_request(input int unsigned insert_pct);
      dwd_pkg::mode_type m;
      int unsigned       roll;
      if ($urandom_range(99) < insert_pct) begin
         m = $urandom_range(1) ? dwd_pkg::MODE_APPEND : dwd_pkg::MODE_PREPEND;
      end else begin
         m = ($urandom_range(99) < 55) ? dwd_pkg::MODE_DEQUEUE : dwd_pkg::MODE_DELETE;
      end
      roll = $urandom_range(99);
      if (shadow_tags.size() != 0 && roll < ((m == dwd_pkg::MODE_DELETE) ? 65 : 20)) begin
         return mk_req(m, shadow_tags[$urandom_range(shadow_tags.size() - 1)]);
      end
      if (roll < 75) begin
         return mk_req(m, tag_pool[$urandom_range(3)]);
      end
      return mk_req(m, $urandom());
   endfunction

   // offers one word, waits for the accept, then idles for gap cycles
   task automatic send_word(input dwd_pkg::req_word_type w, input int unsigned gap);
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      rsp_due.push_back(deque_predict(w));
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
   endtask

   // response side stalls; a hold request keeps it stalled for that many cycles
   always @(negedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req  = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left--;
      end else if (rsp_run_left > 0) begin
         rsp_run_left--;
      end else begin
         rsp_stall    <= ($urandom_range(99) < stall_pct);
         rsp_run_left  = pick_gap();
      end
   end

   always @(posedge clock) begin : check_rsp
      dwd_pkg::rsp_word_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            $error("response word with none expected: %h", rsp_word);
            fail_count++;
         end else begin
            due = rsp_due.pop_front();
            if (rsp_word.status !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_word.status);
               fail_count++;
            end
            if (rsp_word.item_out !== due.item_out) begin
               $error("item_out: expected %h, got %h", due.item_out, rsp_word.item_out);
               fail_count++;
            end
            if (rsp_word.entry_count !== due.entry_count) begin
               $error("entry_count: expected %0d, got %0d", due.entry_count,
                      rsp_word.entry_count);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // empty cases, extremes of the tag, order-keeping delete, full refusal
   task automatic test_directed();
      int unsigned n;
      stall_pct = 0;
      send_word(mk_req(dwd_pkg::MODE_DEQUEUE, 32'h0000_0000), 0);
      send_word(mk_req(dwd_pkg::MODE_DELETE, 32'h0000_0000), 1);
      send_word(mk_req(dwd_pkg::MODE_PREPEND, 32'h0000_0000), 0);  // head wraps below slot 0
      send_word(mk_req(dwd_pkg::MODE_APPEND, 32'hFFFF_FFFF), 2);
      send_word(mk_req(dwd_pkg::MODE_PREPEND, 32'hA5A5_A5A5), 0);
      send_word(mk_req(dwd_pkg::MODE_APPEND, 32'h0000_0000), 0);
      send_word(mk_req(dwd_pkg::MODE_DELETE, 32'h1234_5678), 0);   // no match
      send_word(mk_req(dwd_pkg::MODE_DELETE, 32'h0000_0000), 3);   // two matches, gap between
      send_word(mk_req(dwd_pkg::MODE_DEQUEUE, 32'h5A5A_5A5A), 0);
      for (n = 0; n < dwd_pkg::DEPTH - 1; n++) begin
         send_word(mk_req((n % 2) ? dwd_pkg::MODE_PREPEND : dwd_pkg::MODE_APPEND,
                          32'h5555_AAAA), 0);
      end
      stall_pct = 40;
      send_word(mk_req(dwd_pkg::MODE_PREPEND, 32'h0000_0001), 0);  // refused, full
      send_word(mk_req(dwd_pkg::MODE_APPEND, 32'h0000_0002), 0);   // refused, full
      send_word(mk_req(dwd_pkg::MODE_DELETE, 32'h5555_AAAA), 0);   // full walk
      send_word(mk_req(dwd_pkg::MODE_DELETE, 32'hFFFF_FFFF), 0);   // drains to empty
      send_word(mk_req(dwd_pkg::MODE_APPEND, 32'h7FFF_FFFE), 0);
      send_word(mk_req(dwd_pkg::MODE_DEQUEUE, 32'h0000_0000), 0);
      wait_for_drain();
   endtask

   // phases of random traffic that push occupancy up and down
   task automatic test_random_traffic();
      int unsigned bias [8] = '{70, 30, 85, 15, 50, 90, 20, 55};
      int unsigned phase;
      int unsigned n;
      bit          no_idle;
      for (phase = 0; phase < 13; phase++) begin
         no_idle   = (phase % 4 == 3);
         stall_pct = no_idle ? 0 : ((phase % 2) ? 60 : 25);
         for (n = 0; n < 50; n++) begin
            send_word(pick_request(bias[phase % 8]), no_idle ? 0 : pick_gap());
         end
         wait_for_drain();
      end
   endtask

   // long response hold while words keep coming, so the input stalls
   task automatic test_rsp_backpressure();
      int unsigned n;
      stall_pct    = 0;
      rsp_hold_req = 300;
      for (n = 0; n < 60; n++) begin
         send_word(pick_request(80), 0);
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      test_rsp_backpressure();
      stall_pct = 30;
      test_random_traffic();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (rsp_due.size() != 0) begin
         $error("%0d response words never arrived", rsp_due.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
